// ===== rtl/wrd_pkg.sv =====
// Package for the rank-2 Wigner rotation matrix core.
// Holds widths, Q30 constants, the CORDIC arctangent table and shared types.
// No dependencies.
package wrd_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CORDIC_ITERS      = 30;
    localparam int OUT_W             = 18;
    localparam int IDX_W             = 3;
    localparam int Q_W               = 34;   // Q2.30 plus guard bits

    localparam logic signed [Q_W-1:0] Q30_ONE  = 34'sd1073741824;
    localparam logic signed [Q_W-1:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [Q_W-1:0] SQRT3_8  = 34'sd657529896;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] t;
        unique case (i)
            5'd0:  t = 32'h20000000;  5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;  5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;  5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;  5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;  5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;  5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;  5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;  5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;  5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;  5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;  5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;  5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029;  5'd25: t = 32'h00000014;
            5'd26: t = 32'h0000000A;  5'd27: t = 32'h00000005;
            5'd28: t = 32'h00000003;  5'd29: t = 32'h00000001;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

    // one classified angle set between front and back
    typedef struct packed {
        logic [31:0] alpha;
        logic [31:0] beta;
        logic [31:0] gamma;
        logic        zc;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE, ST_BETA, ST_PREP, ST_ELEM, ST_MUL, ST_OUT
    } t_state;

endpackage

// ===== rtl/wrd_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on wrd_pkg.
module wrd_cordic (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [31:0]                    i_angle,
    output logic                           o_done,
    output logic signed [wrd_pkg::Q_W-1:0] o_cos,
    output logic signed [wrd_pkg::Q_W-1:0] o_sin
);
    import wrd_pkg::*;

    logic signed [Q_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [32:0]    r_z, n_z;
    logic [4:0]            r_it;
    logic                  r_busy, r_flip, r_done;

    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z;
        if (!r_z[32]) begin
            n_x = r_x - (r_y >>> r_it);
            n_y = r_y + (r_x >>> r_it);
            n_z = r_z - $signed({1'b0, atan_turn(r_it)});
        end else begin
            n_x = r_x + (r_y >>> r_it);
            n_y = r_y - (r_x >>> r_it);
            n_z = r_z + $signed({1'b0, atan_turn(r_it)});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                logic [31:0] a;
                logic        fl;
                fl = (i_angle[31:30] == 2'd1) || (i_angle[31:30] == 2'd2);
                a  = fl ? i_angle + 32'h80000000 : i_angle;
                r_flip <= fl;
                r_z    <= $signed({a[31], a});
                r_x    <= CORDIC_K;
                r_y    <= '0;
                r_it   <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_x <= n_x; r_y <= n_y; r_z <= n_z;
                r_it <= r_it + 5'd1;
                if (r_it == 5'(CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

// ===== rtl/wrd_front.sv =====
// Front end: accepts angle sets, widens phases to turn words, queues them.
// Two-entry queue decouples input handshake from the element sequencer.
// Depends on wrd_pkg.
module wrd_front #(
    parameter int ANGLE_BITS = wrd_pkg::ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ANGLE_BITS-1:0] i_alpha,
    input  logic [ANGLE_BITS-1:0] i_beta,
    input  logic [ANGLE_BITS-1:0] i_gamma,
    input  logic                  i_zc,
    output logic                  o_job_valid,
    input  logic                  i_job_take,
    output wrd_pkg::t_job         o_job
);
    import wrd_pkg::*;

    t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job w_job;

    function automatic logic [31:0] widen(input logic [ANGLE_BITS-1:0] p);
        logic [63:0] t;
        t = {{(64-ANGLE_BITS){1'b0}}, p} << (32 - ANGLE_BITS);
        return t[31:0];
    endfunction

    always_comb begin
        w_job.alpha = widen(i_alpha);
        w_job.beta  = widen(i_beta);
        w_job.gamma = widen(i_gamma);
        w_job.zc    = i_zc;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_q[r_wp] <= w_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (i_job_take && o_job_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(i_job_take && o_job_valid);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");

endmodule

// ===== rtl/wrd_back.sv =====
// Back end: beta terms, then per element a CORDIC rotation and two products
// (centre: no rotation, one product). One shared CORDIC; output register toward master.
// Depends on wrd_pkg, wrd_cordic.
module wrd_back #(
    parameter int FRACTION_BITS = wrd_pkg::FRACTION_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    output logic                       o_job_take,
    input  wrd_pkg::t_job              i_job,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [wrd_pkg::IDX_W-1:0]  o_row,
    output logic [wrd_pkg::IDX_W-1:0]  o_col,
    output logic signed [wrd_pkg::OUT_W-1:0] o_re,
    output logic signed [wrd_pkg::OUT_W-1:0] o_im,
    output logic                       o_last
);
    import wrd_pkg::*;

    localparam int SH = 60 - FRACTION_BITS;

    t_state r_st, n_st;
    t_job   r_job;
    logic   c_start;
    logic [31:0] c_ang;
    logic   c_done;
    logic signed [Q_W-1:0] c_cos, c_sin;
    logic signed [Q_W-1:0] r_c, r_s, r_ec, r_es;
    logic signed [Q_W-1:0] r_d [25];
    logic [2:0] r_row, r_col;
    logic signed [67:0] r_pre, r_pim;
    logic [3:0] r_pp;
    // ST_BETA is reused for element rotations; r_elem tells which
    logic r_elem;

    wrd_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(c_start), .i_angle(c_ang),
        .o_done(c_done), .o_cos(c_cos), .o_sin(c_sin)
    );

    function automatic logic signed [Q_W-1:0] mul30(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] b);
        logic signed [67:0] p;
        p = (68'(a) * 68'(b)) + 68'sd536870912;
        return Q_W'(p >>> 30);
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [67:0] p);
        logic signed [67:0] v, lim;
        v   = (p + (68'sd1 <<< (SH - 1))) >>> SH;
        lim = 68'sd1 <<< (FRACTION_BITS + 1);
        if (v > lim - 68'sd1) v = lim - 68'sd1;
        if (v < -lim) v = -lim;
        return OUT_W'(v);
    endfunction

    // element phase -(m*alpha + k*gamma)
    logic [31:0] w_ph;
    always_comb begin
        logic signed [3:0] m, k;
        logic [31:0] sum;
        m = 4'($signed({1'b0, r_row}) - 4'sd2);
        k = 4'($signed({1'b0, r_col}) - 4'sd2);
        sum = 32'($signed(m) * $signed({1'b0, r_job.alpha}))
            + 32'($signed(k) * $signed({1'b0, r_job.gamma}));
        w_ph = 32'h0 - sum;
    end

    logic w_centre, w_lastel, w_out_free;
    assign w_centre   = (r_row == 3'd2) && (r_col == 3'd2);
    assign w_lastel   = (r_row == 3'd4) && (r_col == (r_job.zc ? 3'd2 : 3'd4));
    assign w_out_free = !o_valid || i_ready;

    always_comb begin
        n_st = r_st; c_start = 1'b0; c_ang = r_job.beta; o_job_take = 1'b0;
        unique case (r_st)
            ST_IDLE: if (i_job_valid) begin
                o_job_take = 1'b1;
                c_start = 1'b1;
                c_ang = i_job.beta;
                n_st = ST_BETA;
            end
            ST_BETA: if (c_done) n_st = r_elem ? ST_MUL : ST_PREP;
            ST_PREP: if (r_pp == 4'd3) n_st = ST_ELEM;
            ST_ELEM: begin
                if (w_centre) n_st = ST_MUL;
                else begin
                    c_start = 1'b1;
                    c_ang = w_ph;
                    n_st = ST_BETA;
                end
            end
            ST_MUL: n_st = ST_OUT;
            ST_OUT: if (w_out_free) n_st = w_lastel ? ST_IDLE : ST_ELEM;
            default: n_st = ST_IDLE;
        endcase
    end

    logic signed [Q_W-1:0] r_c2, r_s2, r_cp, r_cm, r_cp2, r_cm2, r_cps, r_cms;
    logic signed [Q_W-1:0] r_sc, r_a2, r_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; o_valid <= 1'b0; r_elem <= 1'b0; r_pp <= '0;
        end else begin
            o_valid <= (r_st == ST_OUT && w_out_free) || (o_valid && !i_ready);
            r_st <= n_st;
            unique case (r_st)
                ST_IDLE: if (i_job_valid) begin
                    r_elem <= 1'b0;
                    r_pp <= '0;
                end
                ST_PREP: r_pp <= r_pp + 4'd1;
                ST_ELEM: r_elem <= 1'b1;
                default: ;
            endcase
        end
    end

    logic [4:0] w_di;
    logic signed [Q_W-1:0] w_dv;
    assign w_di = {2'b00, r_col} * 5'd5 + {2'b00, r_row};
    assign w_dv = r_d[w_di];

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: if (i_job_valid) begin
                r_job <= i_job; r_row <= '0; r_col <= i_job.zc ? 3'd2 : 3'd0;
            end
            ST_BETA: if (c_done) begin
                if (r_elem) begin r_ec <= c_cos; r_es <= c_sin; end
                else begin r_c <= c_cos; r_s <= c_sin; end
            end
            ST_PREP: begin
                unique case (r_pp)
                    4'd0: begin
                        r_c2 <= mul30(r_c, r_c); r_s2 <= mul30(r_s, r_s);
                        r_cp <= (Q30_ONE + r_c) >>> 1; r_cm <= (Q30_ONE - r_c) >>> 1;
                        r_sc <= mul30(r_s, r_c);
                    end
                    4'd1: begin
                        r_cp2 <= mul30(r_cp, r_cp); r_cm2 <= mul30(r_cm, r_cm);
                        r_cps <= mul30(r_cp, r_s);  r_cms <= mul30(r_cm, r_s);
                        r_a2 <= mul30(SQRT3_8, r_sc <<< 1);
                        r_b2 <= mul30(SQRT3_8, r_s2);
                    end
                    4'd2: begin
                        r_d[0] <= r_cp2;  r_d[1] <= -r_cps; r_d[2] <= r_b2;
                        r_d[3] <= -r_cms; r_d[4] <= r_cm2;
                        r_d[5] <= r_cps;  r_d[6] <= r_c2 - r_cm; r_d[7] <= -r_a2;
                        r_d[8] <= r_cp - r_c2; r_d[9] <= -r_cms;
                        r_d[10] <= r_b2;  r_d[11] <= r_a2;
                        r_d[12] <= ((r_c2 + (r_c2 <<< 1)) - Q30_ONE) >>> 1;
                        r_d[13] <= -r_a2; r_d[14] <= r_b2;
                        r_d[15] <= r_cms; r_d[16] <= r_cp - r_c2; r_d[17] <= r_a2;
                        r_d[18] <= r_c2 - r_cm; r_d[19] <= -r_cps;
                        r_d[20] <= r_cm2; r_d[21] <= r_cms; r_d[22] <= r_b2;
                        r_d[23] <= r_cps; r_d[24] <= r_cp2;
                    end
                    default: ;
                endcase
            end
            ST_MUL: begin
                if (w_centre) begin
                    r_pre <= 68'(w_dv) * 68'(Q30_ONE); r_pim <= '0;
                end else begin
                    r_pre <= 68'(w_dv) * 68'(r_ec); r_pim <= 68'(w_dv) * 68'(r_es);
                end
            end
            ST_OUT: if (w_out_free) begin
                o_row <= r_row; o_col <= r_col;
                o_re <= to_out(r_pre); o_im <= w_centre ? '0 : to_out(r_pim);
                o_last <= w_lastel;
                if (r_row == 3'd4) begin r_row <= '0; r_col <= r_col + 3'd1; end
                else r_row <= r_row + 3'd1;
            end
            default: ;
        endcase
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |-> r_st == ST_IDLE) else $error("take while busy");
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_row == 3'd4) else $error("bad last");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_row, o_col, o_re, o_im, o_last}))
        else $error("output changed while stalled");

endmodule

// ===== rtl/wigner_rank2_rotation_matrix_core.sv =====
// Rank-2 Wigner rotation matrix core: 25 (or 5) complex elements per angle set.
// Steps: the beta rotation and d terms once per angle set, then per element
// a 30-step CORDIC rotation (not for the centre), capture, product and out.
// Output stalls hold the element sequence.
// Next angle set is queued (two deep) while the current one is emitted.
// Reset (synchronous, active low) empties queue, sequencer and CORDIC control; datapath registers are not reset.
module wigner_rank2_rotation_matrix_core #(
    parameter int ANGLE_BITS    = wrd_pkg::ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = wrd_pkg::FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // alpha_phase, beta_phase, gamma_phase (ANGLE_BITS each), pad to bytes
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic        s_axis_tuser,    // zero_column_only
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // row_index[2:0], column_index[5:3], real_part[23:6], imag_part[41:24], zero pad
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast     // last_element
);
    import wrd_pkg::*;

    t_job w_job;
    logic w_jv, w_take;
    logic [IDX_W-1:0] w_row, w_col;
    logic signed [OUT_W-1:0] w_re, w_im;

    wrd_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_alpha(s_axis_tdata[ANGLE_BITS-1:0]),
        .i_beta(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
        .i_gamma(s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
        .i_zc(s_axis_tuser),
        .o_job_valid(w_jv), .i_job_take(w_take), .o_job(w_job)
    );

    wrd_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_jv), .o_job_take(w_take), .i_job(w_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_row(w_row), .o_col(w_col), .o_re(w_re), .o_im(w_im), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, w_im, w_re, w_col, w_row};

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for wigner_rank2_rotation_matrix_core: directed and random angle sets.
// Checks every emitted element against a fixed-point CORDIC predictor of the rank-2 matrix.
// Depends on wrd_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
    import wrd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [17:0] re;
        logic [17:0] im;
        logic        last;
    } t_elem;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;     // alpha[15:0], beta[31:16], gamma[47:32]
    logic        s_axis_tuser;     // zero_column_only
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;     // row[2:0], col[5:3], re[23:6], im[41:24], pad
    logic        m_axis_tlast;     // last_element

    t_elem elem_q[$];
    int    n_errors;
    int    n_sets;
    int    n_elems;
    int    idle_cycles;

    wigner_rank2_rotation_matrix_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    function automatic longint mul_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // rotation-mode CORDIC on a 32-bit turn word, Q2.30 out
    function automatic void sincos_turn(input logic [31:0] ang,
                                        output longint cs, output longint sn);
        logic   flip;
        longint x, y, z, dx, dy;
        flip = 1'b0;
        x = longint'(CORDIC_K);
        y = 0;
        if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
            ang  = ang + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(ang));
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turn(5'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turn(5'(i)));
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic logic [17:0] q60_to_out(longint p);
        longint v, lim;
        lim = 64'sd1 <<< (FRACTION_BITS_DEF + 1);
        v = (p + (64'sd1 <<< (59 - FRACTION_BITS_DEF))) >>> (60 - FRACTION_BITS_DEF);
        if (v > lim - 1) v = lim - 1;
        if (v < -lim) v = -lim;
        return v[17:0];
    endfunction

    task automatic predict_matrix(input logic [15:0] a_ph, b_ph, g_ph, input logic zc);
        logic [31:0] al, be, ga, sum;
        longint c, s, c2, s2, cp, cm, cp2, cm2, cps, cms, a2, b2, mid, ec, es, dv;
        longint d[25];
        int first, lastc, m, k;
        t_elem e;
        al = {a_ph, 16'h0};
        be = {b_ph, 16'h0};
        ga = {g_ph, 16'h0};
        sincos_turn(be, c, s);
        c2  = mul_q30(c, c);
        s2  = mul_q30(s, s);
        cp  = (longint'(Q30_ONE) + c) >>> 1;
        cm  = (longint'(Q30_ONE) - c) >>> 1;
        cp2 = mul_q30(cp, cp);
        cm2 = mul_q30(cm, cm);
        cps = mul_q30(cp, s);
        cms = mul_q30(cm, s);
        a2  = mul_q30(longint'(SQRT3_8), 2 * mul_q30(s, c));
        b2  = mul_q30(longint'(SQRT3_8), s2);
        mid = (3 * c2 - longint'(Q30_ONE)) >>> 1;
        d = '{cp2, -cps, b2, -cms, cm2,
              cps, c2 - cm, -a2, cp - c2, -cms,
              b2, a2, mid, -a2, b2,
              cms, cp - c2, a2, c2 - cm, -cps,
              cm2, cms, b2, cps, cp2};
        first = zc ? 2 : 0;
        lastc = zc ? 2 : 4;
        for (int col = first; col <= lastc; col++) begin
            for (int row = 0; row < 5; row++) begin
                dv = d[col * 5 + row];
                e.row = 3'(row);
                e.col = 3'(col);
                if (row == 2 && col == 2) begin
                    e.re = q60_to_out(dv * longint'(Q30_ONE));
                    e.im = '0;
                end else begin
                    m = row - 2;
                    k = col - 2;
                    sum = 32'(m) * al + 32'(k) * ga;
                    sincos_turn(-sum, ec, es);
                    e.re = q60_to_out(dv * ec);
                    e.im = q60_to_out(dv * es);
                end
                e.last = (col == lastc && row == 4);
                elem_q.push_back(e);
            end
        end
    endtask

    // ---------------- stimulus ----------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_angles(input logic [15:0] a_ph, b_ph, g_ph, input logic zc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {g_ph, b_ph, a_ph};
        s_axis_tuser  <= zc;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_matrix(a_ph, b_ph, g_ph, zc);
        n_sets++;
    endtask

    task automatic test_reset();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_corner_angles();
        logic [15:0] corners[8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                                    16'hC000, 16'h2000, 16'h7FFF, 16'h0001};
        foreach (corners[i])
            send_angles(corners[i], corners[7 - i], corners[(i + 3) % 8], 1'b0);
        // beta at zero: d is the identity, beta at half a turn: anti-diagonal
        send_angles(16'h1234, 16'h0000, 16'hABCD, 1'b0);
        send_angles(16'hFEDC, 16'h8000, 16'h5555, 1'b0);
    endtask

    task automatic test_zero_column();
        // gamma must have no effect in this mode
        send_angles(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_angles(16'h3C00, 16'h4000, 16'h0000, 1'b1);
        send_angles(16'h3C00, 16'h4000, 16'hFFFF, 1'b1);
        send_angles(16'hAAAA, 16'hC000, 16'h5555, 1'b1);
        send_angles(16'h5555, 16'h8000, 16'hAAAA, 1'b1);
    endtask

    task automatic test_random_angles(input int count);
        for (int i = 0; i < count; i++)
            send_angles(16'($urandom), 16'($urandom), 16'($urandom),
                        ($urandom_range(0, 99) < 30));
    endtask

    // ---------------- result side ----------------
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall = 0;
        end else if (stall > 0) begin
            stall--;
            m_axis_tready <= 1'b0;
        end else begin
            stall = pick_gap();
            m_axis_tready <= (stall == 0);
        end
    end

    initial m_axis_tready = 1'b0;

    always @(posedge i_clk) begin
        t_elem e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_elems++;
            if (elem_q.size() == 0) begin
                $error("unexpected transaction: tdata=%h", m_axis_tdata);
                n_errors++;
            end else begin
                e = elem_q.pop_front();
                if (m_axis_tdata[2:0] !== e.row) begin
                    $error("row_index: expected %0d actual %0d", e.row, m_axis_tdata[2:0]);
                    n_errors++;
                end
                if (m_axis_tdata[5:3] !== e.col) begin
                    $error("column_index: expected %0d actual %0d", e.col, m_axis_tdata[5:3]);
                    n_errors++;
                end
                if (m_axis_tdata[23:6] !== e.re) begin
                    $error("real_part: expected %0d actual %0d",
                           $signed(e.re), $signed(m_axis_tdata[23:6]));
                    n_errors++;
                end
                if (m_axis_tdata[41:24] !== e.im) begin
                    $error("imag_part: expected %0d actual %0d",
                           $signed(e.im), $signed(m_axis_tdata[41:24]));
                    n_errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_element: expected %0b actual %0b", e.last, m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d elements still pending", elem_q.size());
            $display("** wigner_rank2_rotation_matrix_core: FAILED **");
            $finish;
        end
    end

    initial begin
        n_errors    = 0;
        n_sets      = 0;
        n_elems     = 0;
        idle_cycles = 0;
        test_reset();
        test_corner_angles();
        test_zero_column();
        test_random_angles(114);
        s_axis_tvalid <= 1'b0;
        wait (elem_q.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d angle sets (full matrix and zero column), checked %0d elements.",
                 n_sets, n_elems);
        if (n_errors == 0 && elem_q.size() == 0)
            $display("** wigner_rank2_rotation_matrix_core: PASSED **");
        else
            $display("** wigner_rank2_rotation_matrix_core: FAILED **");
        $finish;
    end

endmodule

// ===== wigner_rank2_rotation_matrix_core.f =====
rtl/wrd_pkg.sv
rtl/wrd_cordic.sv
rtl/wrd_front.sv
rtl/wrd_back.sv
rtl/wigner_rank2_rotation_matrix_core.sv
tb/sv/tb_top.sv
